// ===== hw/rtl/alr_pkg.sv =====
package alr_pkg;

  // fixed-point and coordinate geometry
  localparam int FRAC_BITS  = 16;
  localparam int COORD_BITS = 10;
  localparam int CRD_W      = 26;
  localparam int LVL_W      = 8;
  localparam int ACC_W      = 32;
  localparam int A_W        = CRD_W + 2;
  localparam int IA_W       = A_W - FRAC_BITS;
  localparam int G_W        = FRAC_BITS + 1;

  // long division of |db| << FRAC_BITS by the major length
  localparam int DIV_N_W    = CRD_W + 1 + FRAC_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_N_W);

  // shared multiplier
  localparam int MUL_A_W    = ACC_W + 1;
  localparam int MUL_B_W    = G_W + 1;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;

  localparam logic [A_W-1:0] FX_ONE   = A_W'(64'd1 << FRAC_BITS);
  localparam logic [A_W-1:0] FX_HALF  = A_W'(64'd1 << (FRAC_BITS - 1));
  localparam logic [A_W-1:0] FX_TENTH = A_W'((64'd1 << FRAC_BITS) / 10);

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef struct packed {
    logic             op;
    logic [CRD_W-1:0] x_start;
    logic [CRD_W-1:0] y_start;
    logic [CRD_W-1:0] x_finish;
    logic [CRD_W-1:0] y_finish;
    logic [LVL_W-1:0] brightness;
    logic             erase;
  } alr_in_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [LVL_W-1:0]      near_level;
    logic [LVL_W-1:0]      far_level;
    logic                  steep;
    logic                  last;
  } alr_out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SORT, ST_ORDER, ST_PREP, ST_DIV, ST_FIX, ST_ADJ,
    ST_MD, ST_MM, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    MUL_GRAD, MUL_NFRAC, MUL_FRAC, MUL_S1, MUL_S2
  } mul_sel_e;

  typedef struct packed {
    logic     accept;
    logic     sort;
    logic     order;
    logic     prep;
    logic     div_step;
    logic     fix;
    logic     adj;
    mul_sel_e mul_sel;
    logic     cap_m;
    logic     cap_s1;
    logic     cap_s2;
    logic     cap_ln;
    logic     cap_lf;
    logic     emit;
  } alr_cmd_t;

  typedef struct packed {
    logic out_free;
    logic tenth;
    logic end_last;
  } alr_sts_t;

endpackage

// ===== hw/rtl/alr_ctrl.sv =====
module alr_ctrl
  import alr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_op_i,
  output logic     in_stall_o,
  input  alr_sts_t sts_i,
  output alr_cmd_t cmd_o
);

  state_e               state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;

  // hold state and division count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && sts_i.out_free && (in_op_i == OP_START)) state_d = ST_SORT;
      end
      ST_SORT:  state_d = ST_ORDER;
      ST_ORDER: state_d = ST_PREP;
      ST_PREP: begin
        cnt_d   = '0;
        state_d = sts_i.tenth ? ST_FIX : ST_DIV;
      end
      ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_N_W - 1)) state_d = ST_FIX;
      end
      ST_FIX: state_d = ST_ADJ;
      ST_ADJ: state_d = ST_MD;
      ST_MD:  state_d = ST_MM;
      ST_MM:  state_d = ST_P1;
      ST_P1:  state_d = ST_P2;
      ST_P2:  state_d = ST_P3;
      ST_P3:  state_d = ST_P4;
      ST_P4:  state_d = ST_P5;
      ST_P5:  state_d = ST_EMIT;
      ST_EMIT: begin
        if (sts_i.out_free) state_d = sts_i.end_last ? ST_IDLE : ST_MD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_GRAD;
    in_stall_o    = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o   = !sts_i.out_free;
        cmd_o.accept = in_valid_i && sts_i.out_free;
      end
      ST_SORT:  cmd_o.sort     = 1'b1;
      ST_ORDER: cmd_o.order    = 1'b1;
      ST_PREP:  cmd_o.prep     = 1'b1;
      ST_DIV:   cmd_o.div_step = 1'b1;
      ST_FIX:   cmd_o.fix      = 1'b1;
      ST_ADJ:   cmd_o.adj      = 1'b1;
      ST_MD:    cmd_o.mul_sel  = MUL_GRAD;
      ST_MM:    cmd_o.cap_m    = 1'b1;
      ST_P1:    cmd_o.mul_sel  = MUL_NFRAC;
      ST_P2: begin
        cmd_o.cap_s1  = 1'b1;
        cmd_o.mul_sel = MUL_FRAC;
      end
      ST_P3: begin
        cmd_o.cap_s2  = 1'b1;
        cmd_o.mul_sel = MUL_S1;
      end
      ST_P4: begin
        cmd_o.cap_ln  = 1'b1;
        cmd_o.mul_sel = MUL_S2;
      end
      ST_P5:   cmd_o.cap_lf = 1'b1;
      ST_EMIT: cmd_o.emit   = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ===== hw/rtl/alr_dp.sv =====
module alr_dp
  import alr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  alr_in_t  in_data_i,
  input  alr_cmd_t cmd_i,
  output alr_sts_t sts_o,
  input  logic     out_stall_i,
  output logic     out_valid_o,
  output alr_out_t out_data_o
);

  logic [CRD_W-1:0]         xs_q, ys_q, xf_q, yf_q;
  logic [LVL_W-1:0]         br_q;
  logic                     er_q, stp_q;
  logic [CRD_W-1:0]         a1_q, a2_q, b1_q, b2_q, ad_q, ad_c, rem_q;
  logic                     neg_q;
  logic [DIV_N_W-1:0]       num_q;
  logic [ACC_W-1:0]         grad_q, m_q, acc_q;
  logic [A_W-1:0]           a1n_q, a2n_q, a1n_d, a2n_d;
  logic [ACC_W-1:0]         b1n_q, b2n_q, b1n_d, b2n_d;
  logic                     end_q, active_q;
  logic [G_W-1:0]           s1_q, s2_q;
  logic [LVL_W-1:0]         ln_q, lf_q;
  logic [COORD_BITS-1:0]    pos_q, stop_q;
  logic signed [PROD_W-1:0] prod_q;
  logic                     out_valid_q;
  alr_out_t                 out_q, out_d;
  logic                     out_load, out_free;

  // pack a pixel pair, placing major and minor by the axis
  function automatic alr_out_t pack_pair(input logic stp, input logic [COORD_BITS-1:0] major,
                                         input logic [COORD_BITS-1:0] minor,
                                         input logic [LVL_W-1:0] nl,
                                         input logic [LVL_W-1:0] fl, input logic lst);
    alr_out_t o;
    o.pixel_x    = stp ? minor : major;
    o.pixel_y    = stp ? major : minor;
    o.near_level = nl;
    o.far_level  = fl;
    o.steep      = stp;
    o.last       = lst;
    return o;
  endfunction

  // axis choice
  logic [CRD_W:0] dx, dy, adx, ady;
  always_comb begin
    dx  = {1'b0, xf_q} - {1'b0, xs_q};
    dy  = {1'b0, yf_q} - {1'b0, ys_q};
    adx = dx[CRD_W] ? (~dx + 1'b1) : dx;
    ady = dy[CRD_W] ? (~dy + 1'b1) : dy;
  end

  // endpoint order along the major axis
  logic [CRD_W-1:0] pa1, pb1, pa2, pb2;
  logic             swap;
  always_comb begin
    pa1  = stp_q ? ys_q : xs_q;
    pb1  = stp_q ? xs_q : ys_q;
    pa2  = stp_q ? yf_q : xf_q;
    pb2  = stp_q ? xf_q : yf_q;
    swap = pa2 < pa1;
  end

  // length and minor difference
  logic [CRD_W:0] db, dmag;
  always_comb begin
    ad_c = a2_q - a1_q;
    db   = {1'b0, b2_q} - {1'b0, b1_q};
    dmag = db[CRD_W] ? (~db + 1'b1) : db;
  end

  // one restoring division step
  logic [CRD_W:0] r_sh, r_sub;
  logic           r_ge;
  always_comb begin
    r_sh  = {rem_q, num_q[DIV_N_W-1]};
    r_sub = r_sh - {1'b0, ad_q};
    r_ge  = r_sh >= {1'b0, ad_q};
  end

  // widen near-zero and short lines
  logic           tenth_c, short_c;
  logic [CRD_W:0] sum_a, sum_b;
  logic [A_W-1:0] am, a1e;
  logic [ACC_W-1:0] bm, gh;
  always_comb begin
    tenth_c = {2'b00, ad_q} < FX_TENTH;
    short_c = {2'b00, ad_q} < FX_ONE;
    sum_a   = {1'b0, a1_q} + {1'b0, a2_q};
    sum_b   = {1'b0, b1_q} + {1'b0, b2_q};
    am      = {2'b00, sum_a[CRD_W:1]};
    bm      = {{(ACC_W-CRD_W){1'b0}}, sum_b[CRD_W:1]};
    gh      = {grad_q[ACC_W-1], grad_q[ACC_W-1:1]};
    a1e     = {2'b00, a1_q};
    if (tenth_c) begin
      a1n_d = a1e - FX_HALF;
      a2n_d = a1e + FX_HALF;
      b1n_d = {{(ACC_W-CRD_W){1'b0}}, b1_q};
      b2n_d = {{(ACC_W-CRD_W){1'b0}}, b2_q};
    end else if (short_c) begin
      a1n_d = am - FX_HALF;
      a2n_d = am + FX_HALF;
      b1n_d = bm - gh;
      b2n_d = bm + gh;
    end else begin
      a1n_d = a1e;
      a2n_d = {2'b00, a2_q};
      b1n_d = {{(ACC_W-CRD_W){1'b0}}, b1_q};
      b2n_d = {{(ACC_W-CRD_W){1'b0}}, b2_q};
    end
  end

  // endpoint terms: pixel, offset to pixel centre, coverage weight
  logic [A_W-1:0]    ah1, ah2, ahe, ae, ee, dlt;
  logic [G_W-1:0]    gw, nfrac;
  logic [IA_W-1:0]   ia1, ia2, iae;
  logic [IA_W:0]     ia1p, ia2x;
  logic              spans;
  logic [ACC_W-1:0]  be;
  always_comb begin
    ah1   = a1n_q + FX_HALF;
    ah2   = a2n_q + FX_HALF;
    ahe   = end_q ? ah2 : ah1;
    ae    = end_q ? a2n_q : a1n_q;
    be    = end_q ? b2n_q : b1n_q;
    ee    = {ahe[A_W-1:FRAC_BITS], {FRAC_BITS{1'b0}}};
    dlt   = ee - ae;
    gw    = end_q ? {1'b0, ahe[FRAC_BITS-1:0]}
                  : (G_W'(FX_ONE) - {1'b0, ahe[FRAC_BITS-1:0]});
    nfrac = G_W'(FX_ONE) - {1'b0, m_q[FRAC_BITS-1:0]};
    ia1   = ah1[A_W-1:FRAC_BITS];
    ia2   = ah2[A_W-1:FRAC_BITS];
    iae   = end_q ? ia2 : ia1;
    ia1p  = {ia1[IA_W-1], ia1} + 1'b1;
    ia2x  = {ia2[IA_W-1], ia2};
    spans = ($signed(ia2x) > $signed(ia1p))
            && (ia2[COORD_BITS-1:0] != ia1p[COORD_BITS-1:0]);
  end

  // shared multiplier operands
  logic signed [MUL_A_W-1:0] ma;
  logic signed [MUL_B_W-1:0] mb;
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.mul_sel)
      MUL_GRAD: begin
        ma = {grad_q[ACC_W-1], grad_q};
        mb = {dlt[G_W-1], dlt[G_W-1:0]};
      end
      MUL_NFRAC: begin
        ma = {{(MUL_A_W-G_W){1'b0}}, nfrac};
        mb = {1'b0, gw};
      end
      MUL_FRAC: begin
        ma = {{(MUL_A_W-FRAC_BITS){1'b0}}, m_q[FRAC_BITS-1:0]};
        mb = {1'b0, gw};
      end
      MUL_S1: begin
        ma = {{(MUL_A_W-G_W){1'b0}}, s1_q};
        mb = {{(MUL_B_W-LVL_W){1'b0}}, br_q};
      end
      MUL_S2: begin
        ma = {{(MUL_A_W-G_W){1'b0}}, s2_q};
        mb = {{(MUL_B_W-LVL_W){1'b0}}, br_q};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // span step levels
  logic [FRAC_BITS+LVL_W-1:0] sp;
  logic [LVL_W-1:0]           sfar, snear;
  logic [COORD_BITS-1:0]      snext;
  logic                       do_step;
  always_comb begin
    sp      = acc_q[FRAC_BITS-1:0] * br_q;
    sfar    = sp[FRAC_BITS+LVL_W-1:FRAC_BITS];
    snear   = br_q - sfar;
    snext   = pos_q + 1'b1;
    do_step = cmd_i.accept && (in_data_i.op == OP_STEP) && active_q;
  end

  // result register load
  always_comb begin
    out_free = !out_valid_q || !out_stall_i;
    out_load = cmd_i.emit || do_step;
    out_d    = out_q;
    if (cmd_i.emit) begin
      out_d = pack_pair(stp_q, iae[COORD_BITS-1:0],
                        m_q[FRAC_BITS+COORD_BITS-1:FRAC_BITS],
                        er_q ? '0 : ln_q, er_q ? '0 : lf_q, end_q && !spans);
    end else if (do_step) begin
      out_d = pack_pair(stp_q, pos_q, acc_q[FRAC_BITS+COORD_BITS-1:FRAC_BITS],
                        er_q ? '0 : snear, er_q ? '0 : sfar, snext == stop_q);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      active_q    <= 1'b0;
      end_q       <= 1'b0;
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (cmd_i.adj) end_q <= 1'b0;
      else if (cmd_i.emit) end_q <= 1'b1;
      if (cmd_i.emit && end_q) active_q <= spans;
      else if (do_step && (snext == stop_q)) active_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(ma * mb);
    if (out_load) out_q <= out_d;
    if (cmd_i.accept && (in_data_i.op == OP_START)) begin
      xs_q <= in_data_i.x_start;
      ys_q <= in_data_i.y_start;
      xf_q <= in_data_i.x_finish;
      yf_q <= in_data_i.y_finish;
      br_q <= in_data_i.brightness;
      er_q <= in_data_i.erase;
    end
    if (cmd_i.sort) stp_q <= !(adx > ady);
    if (cmd_i.order) begin
      a1_q <= swap ? pa2 : pa1;
      a2_q <= swap ? pa1 : pa2;
      b1_q <= swap ? pb2 : pb1;
      b2_q <= swap ? pb1 : pb2;
    end
    if (cmd_i.prep) begin
      ad_q  <= ad_c;
      neg_q <= db[CRD_W];
      num_q <= {dmag, {FRAC_BITS{1'b0}}};
      rem_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= r_ge ? r_sub[CRD_W-1:0] : r_sh[CRD_W-1:0];
      num_q <= {num_q[DIV_N_W-2:0], r_ge};
    end
    if (cmd_i.fix) begin
      if (tenth_c) grad_q <= '0;
      else grad_q <= neg_q ? (~num_q[ACC_W-1:0] + 1'b1) : num_q[ACC_W-1:0];
    end
    if (cmd_i.adj) begin
      a1n_q <= a1n_d;
      a2n_q <= a2n_d;
      b1n_q <= b1n_d;
      b2n_q <= b2n_d;
    end
    if (cmd_i.cap_m)  m_q  <= be + prod_q[ACC_W+FRAC_BITS-1:FRAC_BITS];
    if (cmd_i.cap_s1) s1_q <= prod_q[G_W+FRAC_BITS-1:FRAC_BITS];
    if (cmd_i.cap_s2) s2_q <= prod_q[G_W+FRAC_BITS-1:FRAC_BITS];
    if (cmd_i.cap_ln) ln_q <= prod_q[LVL_W+FRAC_BITS-1:FRAC_BITS];
    if (cmd_i.cap_lf) lf_q <= prod_q[LVL_W+FRAC_BITS-1:FRAC_BITS];
    // advance span state
    if (cmd_i.emit && !end_q) begin
      acc_q <= m_q + grad_q;
      pos_q <= ia1p[COORD_BITS-1:0];
    end else if (do_step) begin
      acc_q <= acc_q + grad_q;
      pos_q <= snext;
    end
    if (cmd_i.emit && end_q) stop_q <= ia2[COORD_BITS-1:0];
  end

  assign sts_o.out_free = out_free;
  assign sts_o.tenth    = {2'b00, ad_c} < FX_TENTH;
  assign sts_o.end_last = end_q;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule

// ===== hw/rtl/antialiased_line_rasterizer.sv =====
// Antialiased line rasterizer, Wu's method in 10.16 fixed point.
// Input channel: in_valid_i / in_stall_o with an alr_in_t beat. A beat with
// op = start sets up a line and returns two beats: the weighted start and end
// pixel pairs. A beat with op = step returns the next span pixel pair, or
// nothing when no line is active. The beat marked last closes the line.
// Output channel: out_valid_o / out_stall_i with an alr_out_t beat, held in
// one output register.
// Setup: a start beat runs sort, order and prep, then the bit-serial gradient
// division (skipped when the line is near zero length), fix and adjust; each
// of the two results then takes the multiply states MD, MM and P1 to P5.
// All endpoint products go through one shared multiplier.
// Step beats run at one per cycle, each result loaded straight into the
// output register, taken while that register is empty or being drained.
// Stall: a stalled output beat holds; input is then stalled too.
// Reset: no line active, output empty, block ready for a start beat.
module antialiased_line_rasterizer
  import alr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  alr_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output alr_out_t out_data_o
);

  alr_cmd_t cmd;
  alr_sts_t sts;

  alr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_data_i.op),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  alr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

`ifndef ASSERT_OFF
  // input is taken only when the output register has room
  ast_in_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> (!out_valid_o || !out_stall_i))
    else $error("input taken while output register full");

  // a start beat occupies the block
  ast_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_data_i.op == OP_START)) |=> in_stall_o)
    else $error("input taken during line setup");
`endif

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import alr_pkg::*;

  localparam longint FxOne   = longint'(1) <<< FRAC_BITS;
  localparam longint FxHalf  = longint'(1) <<< (FRAC_BITS - 1);
  localparam longint FxTenth = FxOne / 10;
  localparam longint FxMask  = FxOne - 1;
  localparam longint CrdMax  = 64'd41943040;
  localparam int     StallLimit = 3000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  alr_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  alr_out_t out_data_o;

  antialiased_line_rasterizer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // predicted line state
  bit                    line_active;
  bit                    line_steep;
  int                    line_minor;
  int                    line_grad;
  logic [COORD_BITS-1:0] line_pos;
  logic [COORD_BITS-1:0] line_stop;
  logic [LVL_W-1:0]      line_level;
  bit                    line_erase;

  alr_out_t pixel_q[$];
  int       mismatches;
  int       items_sent;
  bit       no_idle;
  int       rx_wait;
  int       rx_hold;
  int       quiet_cycles;

  function automatic longint fx_mul(longint a, longint b);
    return (a * b) >>> FRAC_BITS;
  endfunction

  function automatic alr_out_t pixel_pair(bit stp, longint major, longint minor,
                                          longint nl, longint fl, bit lst);
    alr_out_t r;
    r.pixel_x    = stp ? minor[COORD_BITS-1:0] : major[COORD_BITS-1:0];
    r.pixel_y    = stp ? major[COORD_BITS-1:0] : minor[COORD_BITS-1:0];
    r.near_level = nl[LVL_W-1:0];
    r.far_level  = fl[LVL_W-1:0];
    r.steep      = stp;
    r.last       = lst;
    return r;
  endfunction

  // work out the pixel pairs caused by one accepted beat
  task automatic predict_pixels(alr_in_t it);
    longint xs, ys, xf, yf, br, dx, dy, a1, b1, a2, b2, ad, grad, t, am, bm;
    longint e1, m1, g1, s1, s2, e2, m2, g2, ia1, ia2, bb, far_l, near_l;
    longint l1n, l1f, l2n, l2f;
    bit stp, spans, lst;
    logic [COORD_BITS-1:0] nxt;
    if (it.op == OP_START) begin
      xs = it.x_start; ys = it.y_start; xf = it.x_finish; yf = it.y_finish;
      br = it.brightness;
      dx = xf - xs; dy = yf - ys;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      stp = !(dx > dy);
      if (stp) begin
        a1 = ys; b1 = xs; a2 = yf; b2 = xf;
      end else begin
        a1 = xs; b1 = ys; a2 = xf; b2 = yf;
      end
      if (a2 < a1) begin
        t = a1; a1 = a2; a2 = t;
        t = b1; b1 = b2; b2 = t;
      end
      ad = a2 - a1;
      if (ad < FxTenth) begin
        a2 = a1 + FxHalf;
        a1 = a1 - FxHalf;
        grad = 0;
      end else begin
        grad = ((b2 - b1) * FxOne) / ad;
        // widen a sub-pixel line about its midpoint
        if (ad < FxOne) begin
          am = (a1 + a2) >>> 1;
          bm = (b1 + b2) >>> 1;
          a1 = am - FxHalf;
          a2 = am + FxHalf;
          b1 = bm - (grad >>> 1);
          b2 = bm + (grad >>> 1);
        end
      end
      e1 = ((a1 + FxHalf) >>> FRAC_BITS) * FxOne;
      m1 = b1 + fx_mul(grad, e1 - a1);
      g1 = FxOne - ((a1 + FxHalf) & FxMask);
      s1 = fx_mul(FxOne - (m1 & FxMask), g1);
      s2 = fx_mul(m1 & FxMask, g1);
      l1n = it.erase ? 0 : (s1 * br) >>> FRAC_BITS;
      l1f = it.erase ? 0 : (s2 * br) >>> FRAC_BITS;
      ia1 = e1 >>> FRAC_BITS;
      e2 = ((a2 + FxHalf) >>> FRAC_BITS) * FxOne;
      m2 = b2 + fx_mul(grad, e2 - a2);
      g2 = (a2 - FxHalf) & FxMask;
      s1 = fx_mul(FxOne - (m2 & FxMask), g2);
      s2 = fx_mul(m2 & FxMask, g2);
      l2n = it.erase ? 0 : (s1 * br) >>> FRAC_BITS;
      l2f = it.erase ? 0 : (s2 * br) >>> FRAC_BITS;
      ia2 = e2 >>> FRAC_BITS;
      t = ia1 + 1;
      spans = (ia2 - t > 0) && (ia2[COORD_BITS-1:0] != t[COORD_BITS-1:0]);
      pixel_q.push_back(pixel_pair(stp, ia1, m1 >>> FRAC_BITS, l1n, l1f, 1'b0));
      pixel_q.push_back(pixel_pair(stp, ia2, m2 >>> FRAC_BITS, l2n, l2f, !spans));
      line_active = spans;
      line_steep  = stp;
      t = m1 + grad;
      line_minor  = t[31:0];
      line_grad   = grad[31:0];
      t = ia1 + 1;
      line_pos    = t[COORD_BITS-1:0];
      line_stop   = ia2[COORD_BITS-1:0];
      line_level  = it.brightness;
      line_erase  = it.erase;
    end else if (line_active) begin
      bb = longint'(line_minor);
      far_l = ((bb & FxMask) * line_level) >>> FRAC_BITS;
      near_l = line_level - far_l;
      if (line_erase) begin
        far_l = 0; near_l = 0;
      end
      nxt = line_pos + 1'b1;
      lst = nxt == line_stop;
      pixel_q.push_back(pixel_pair(line_steep, line_pos, bb >>> FRAC_BITS,
                                   near_l, far_l, lst));
      line_minor = line_minor + line_grad;
      line_pos   = nxt;
      if (lst) line_active = 1'b0;
    end
  endtask

  // offer one beat after a random gap, hold it until taken
  task automatic send_beat(alr_in_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      @(negedge clk_i) in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i  = it;
    do @(posedge clk_i); while (in_stall_o);
    predict_pixels(it);
    items_sent++;
  endtask

  task automatic send_line(longint xs, longint ys, longint xf, longint yf,
                           int br, bit er);
    alr_in_t it;
    it.op = OP_START;
    it.x_start = xs[CRD_W-1:0]; it.y_start = ys[CRD_W-1:0];
    it.x_finish = xf[CRD_W-1:0]; it.y_finish = yf[CRD_W-1:0];
    it.brightness = br[LVL_W-1:0];
    it.erase = er;
    send_beat(it);
  endtask

  task automatic send_step();
    alr_in_t    it;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(alr_in_t)-1:0];
    it.op = OP_STEP;
    send_beat(it);
  endtask

  task automatic finish_span();
    while (line_active) send_step();
  endtask

  task automatic drain_pixels();
    @(negedge clk_i) in_valid_i = 1'b0;
    wait (pixel_q.size() == 0);
  endtask

  function automatic longint rand_coord();
    return longint'($urandom_range(0, 32'd41943040));
  endfunction

  function automatic longint near_coord(longint c, int reach);
    longint v;
    v = c + longint'($urandom_range(0, 2 * reach)) - reach;
    if (v < 0) v = 0;
    if (v > CrdMax) v = CrdMax;
    return v;
  endfunction

  task automatic test_directed();
    send_step();                                           // idle step, ignored
    send_line(100 << 16, 50 << 16, 100 << 16, 50 << 16, 255, 0);  // zero length
    send_line(0, 0, 3000, 1000, 255, 0);                   // below a tenth
    send_line(10 << 16, 10 << 16, (10 << 16) + 40000, (10 << 16) + 9000, 200, 0);
    send_line(0, 0, 20000, 50000, 255, 0);                 // short, steep, at origin
    send_line(5 << 16, 5 << 16, 12 << 16, 12 << 16, 128, 0);  // tie counts steep
    finish_span();
    send_line(30 << 16, 8 << 16, 3 << 16, 2 << 16, 255, 0);   // reversed ends
    finish_span();
    send_line(CrdMax, CrdMax, CrdMax - (6 << 16), CrdMax - 123456, 77, 0);
    finish_span();
    send_line(1 << 16, 2 << 16, 9 << 16, 40 << 16, 0, 0);     // brightness 0
    finish_span();
    send_line(12345, 678901, 8 << 16, 3 << 16, 255, 1);       // erase
    finish_span();
    send_line(2 << 16, 2 << 16, 40 << 16, 9 << 16, 255, 0);
    send_step(); send_step();
    send_line(3 << 16, 3 << 16, 3 << 16, 30 << 16, 99, 0);    // start while active
    finish_span();
    send_step();
    send_line(1 << 16, 1 << 16, 2 << 16, 1 << 16, 255, 0);    // no span
    send_line(0, CrdMax, CrdMax, 0, 255, 0);                  // long span
    finish_span();
    drain_pixels();
  endtask

  task automatic test_backpressure();
    rx_hold = 300;
    no_idle = 1'b1;
    send_line(4 << 16, 100 << 16, 60 << 16, 90 << 16, 255, 0);
    finish_span();
    no_idle = 1'b0;
    drain_pixels();
  endtask

  task automatic test_random(int count);
    longint xs, ys;
    int reach, r;
    while (items_sent < count) begin
      no_idle = ($urandom_range(0, 9) == 0);
      xs = rand_coord();
      ys = rand_coord();
      r = $urandom_range(0, 19);
      reach = (r == 0) ? (300 << 16) : (r < 4) ? 65536 : (16 << 16);
      send_line(xs, ys, near_coord(xs, reach), near_coord(ys, reach),
                $urandom_range(0, 255), $urandom_range(0, 7) == 0);
      r = $urandom_range(0, 9);
      // drop the line early now and then, otherwise run it out
      while (line_active && !(r == 0 && $urandom_range(0, 3) == 0)) send_step();
      if ($urandom_range(0, 4) == 0) send_step();
      if ($urandom_range(0, 29) == 0) drain_pixels();
    end
    no_idle = 1'b0;
    drain_pixels();
  endtask

  // receiver stall: a random wait per beat, plus a long hold set by the backpressure test
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      out_stall_i = 1'b1;
      rx_hold--;
    end else if (rx_wait > 0) begin
      out_stall_i = 1'b1;
      rx_wait--;
    end else begin
      out_stall_i = 1'b0;
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    alr_out_t want;
    if (out_valid_o && !out_stall_i) begin
      rx_wait = no_idle ? 0 : $urandom_range(0, 7);
      if (pixel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %p", out_data_o);
      end else begin
        want = pixel_q.pop_front();
        if (out_data_o !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, out_data_o);
        end
      end
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("FAIL antialiased_line_rasterizer");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    test_directed();
    test_backpressure();
    test_random(1150);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && pixel_q.size() == 0) begin
      $display("PASS antialiased_line_rasterizer");
    end else begin
      $display("FAIL antialiased_line_rasterizer");
    end
    $finish;
  end

endmodule
